// ===== rtl/core/ktbv_pkg.sv =====
// Shared types, constants and rounding helpers for the key-twist to base-velocity block.
// Used by every module under rtl/core; depends on nothing.
package ktbv_pkg;

    // field and datapath widths
    localparam int QW  = 16;        // quaternion component
    localparam int PW  = 16;        // position / offset component
    localparam int VW  = 20;        // output velocity
    localparam int RW  = 34;        // rotation matrix entry, 2^-28 units
    localparam int TW  = 17;        // signed twist magnitude
    localparam int TPW = RW + TW;   // R entry times twist
    localparam int OPW = RW + PW;   // R entry times offset
    localparam int RDW = 53;        // rounding input at 2^-28
    localparam int RRW = RDW - 28;  // rounded to 2^-16 (or 2^-12 for offsets)
    localparam int C1W = PW + RRW;  // p times rotated angular term
    localparam int C2W = RRW + RRW; // rotated angular times rotated offset
    localparam int CPW = 52;        // cross product difference
    localparam int CRW = CPW - 12;  // cross product rounded to 2^-16
    localparam int SW  = 42;        // sum before saturation

    localparam int VEL_MAX = 524287;
    localparam int VEL_MIN = -524288;

    localparam logic signed [RW-1:0] ONE_Q28 = RW'(268435456);
    localparam logic [15:0] JOG_SPEED_RST = 16'd2294;

    // configuration register indexes
    localparam logic [1:0] REG_JOG_SPEED = 2'd0;
    localparam logic [1:0] REG_OFF_X     = 2'd1;
    localparam logic [1:0] REG_OFF_Y     = 2'd2;
    localparam logic [1:0] REG_OFF_Z     = 2'd3;

    // twist axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // key codes (ASCII)
    localparam logic [7:0] KEY_LIN_XP = 8'h77; // w
    localparam logic [7:0] KEY_LIN_XN = 8'h73; // s
    localparam logic [7:0] KEY_LIN_YP = 8'h61; // a
    localparam logic [7:0] KEY_LIN_YN = 8'h64; // d
    localparam logic [7:0] KEY_LIN_ZP = 8'h72; // r
    localparam logic [7:0] KEY_LIN_ZN = 8'h66; // f
    localparam logic [7:0] KEY_ANG_XP = 8'h57; // W
    localparam logic [7:0] KEY_ANG_XN = 8'h53; // S
    localparam logic [7:0] KEY_ANG_YP = 8'h41; // A
    localparam logic [7:0] KEY_ANG_YN = 8'h44; // D
    localparam logic [7:0] KEY_ANG_ZP = 8'h52; // R
    localparam logic [7:0] KEY_ANG_ZN = 8'h46; // F
    localparam logic [7:0] KEY_QUIT   = 8'h71; // q

    typedef struct packed {
        logic [7:0]           key_code;
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [PW-1:0] cam_pos_x;
        logic signed [PW-1:0] cam_pos_y;
        logic signed [PW-1:0] cam_pos_z;
    } ktbv_req_t;

    typedef struct packed {
        logic signed [VW-1:0] lin_vel_x;
        logic signed [VW-1:0] lin_vel_y;
        logic signed [VW-1:0] lin_vel_z;
        logic signed [VW-1:0] ang_vel_x;
        logic signed [VW-1:0] ang_vel_y;
        logic signed [VW-1:0] ang_vel_z;
        logic                 quit_flag;
    } ktbv_rsp_t;

    // decoded key
    typedef struct packed {
        logic [1:0]           axis;
        logic                 is_lin;
        logic                 is_ang;
        logic signed [TW-1:0] mag;
        logic                 quit;
    } ktbv_twist_t;

    // rotation stage to transform stage
    typedef struct packed {
        ktbv_twist_t          tw;
        logic [8:0][RW-1:0]   r;
        logic [2:0][PW-1:0]   p;
    } ktbv_rot_t;

    // transform stage to adjoint stage
    typedef struct packed {
        logic                quit;
        logic [2:0][PW-1:0]  p;
        logic [2:0][RRW-1:0] rl;
        logic [2:0][RRW-1:0] ra;
        logic [2:0][RRW-1:0] ro;
    } ktbv_xf_t;

    localparam logic signed [RDW-1:0] HALF28 = {{(RDW-28){1'b0}}, 1'b1, {27{1'b0}}};
    localparam logic signed [CPW-1:0] HALF12 = {{(CPW-12){1'b0}}, 1'b1, {11{1'b0}}};
    localparam logic signed [SW-1:0]  VMAX_S = SW'(VEL_MAX);
    localparam logic signed [SW-1:0]  VMIN_S = SW'(VEL_MIN);

    // round half up, drop 28 fraction bits
    function automatic logic signed [RRW-1:0] rnd28(input logic signed [RDW-1:0] v);
        logic signed [RDW-1:0] t;
        t = v + HALF28;
        return $signed(t[RDW-1:28]);
    endfunction

    // round half up, drop 12 fraction bits
    function automatic logic signed [CRW-1:0] rnd12(input logic signed [CPW-1:0] v);
        logic signed [CPW-1:0] t;
        t = v + HALF12;
        return $signed(t[CPW-1:12]);
    endfunction

    function automatic logic signed [VW-1:0] sat_vel(input logic signed [SW-1:0] v);
        logic signed [VW-1:0] r;
        if (v > VMAX_S)
            r = VW'(VEL_MAX);
        else if (v < VMIN_S)
            r = VW'(VEL_MIN);
        else
            r = $signed(v[VW-1:0]);
        return r;
    endfunction

endpackage

// ===== rtl/core/ktbv_rot.sv =====
// Stages 1-2: key decode, quaternion products, rotation matrix build.
// Depends on ktbv_pkg.
module ktbv_rot (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ktbv_pkg::ktbv_req_t   in_req,
    input  logic [15:0]           jog_speed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ktbv_pkg::ktbv_rot_t   out_rot
);
    import ktbv_pkg::*;

    logic v1_reg, v2_reg;
    logic ld1, ld2;

    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    ktbv_twist_t        tw_reg, tw_next;
    logic [2:0][PW-1:0] p_reg;
    ktbv_rot_t          rot_reg, rot_next;

    logic signed [RW-1:0] xx_e, yy_e, zz_e, xy_e, xz_e, yz_e, wx_e, wy_e, wz_e;
    logic signed [TW-1:0] spd_s;

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    assign spd_s = $signed({1'b0, jog_speed});

    always_comb
    begin
        logic neg;
        neg            = 1'b0;
        tw_next.axis   = AX_X;
        tw_next.is_lin = 1'b0;
        tw_next.is_ang = 1'b0;
        tw_next.quit   = 1'b0;
        unique case (in_req.key_code)
            KEY_LIN_XP: begin tw_next.is_lin = 1'b1; tw_next.axis = AX_X; end
            KEY_LIN_XN: begin tw_next.is_lin = 1'b1; tw_next.axis = AX_X; neg = 1'b1; end
            KEY_LIN_YP: begin tw_next.is_lin = 1'b1; tw_next.axis = AX_Y; end
            KEY_LIN_YN: begin tw_next.is_lin = 1'b1; tw_next.axis = AX_Y; neg = 1'b1; end
            KEY_LIN_ZP: begin tw_next.is_lin = 1'b1; tw_next.axis = AX_Z; end
            KEY_LIN_ZN: begin tw_next.is_lin = 1'b1; tw_next.axis = AX_Z; neg = 1'b1; end
            KEY_ANG_XP: begin tw_next.is_ang = 1'b1; tw_next.axis = AX_X; end
            KEY_ANG_XN: begin tw_next.is_ang = 1'b1; tw_next.axis = AX_X; neg = 1'b1; end
            KEY_ANG_YP: begin tw_next.is_ang = 1'b1; tw_next.axis = AX_Y; end
            KEY_ANG_YN: begin tw_next.is_ang = 1'b1; tw_next.axis = AX_Y; neg = 1'b1; end
            KEY_ANG_ZP: begin tw_next.is_ang = 1'b1; tw_next.axis = AX_Z; end
            KEY_ANG_ZN: begin tw_next.is_ang = 1'b1; tw_next.axis = AX_Z; neg = 1'b1; end
            KEY_QUIT:   tw_next.quit = 1'b1;
            default:    ;
        endcase
        if (!(tw_next.is_lin || tw_next.is_ang))
            tw_next.mag = '0;
        else if (neg)
            tw_next.mag = -spd_s;
        else
            tw_next.mag = spd_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= in_valid;
            if (ld2)
                v2_reg <= v1_reg;
        end
    end

    // stage 1: quaternion products
    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            xx_reg <= in_req.quat_x * in_req.quat_x;
            yy_reg <= in_req.quat_y * in_req.quat_y;
            zz_reg <= in_req.quat_z * in_req.quat_z;
            xy_reg <= in_req.quat_x * in_req.quat_y;
            xz_reg <= in_req.quat_x * in_req.quat_z;
            yz_reg <= in_req.quat_y * in_req.quat_z;
            wx_reg <= in_req.quat_w * in_req.quat_x;
            wy_reg <= in_req.quat_w * in_req.quat_y;
            wz_reg <= in_req.quat_w * in_req.quat_z;
            tw_reg <= tw_next;
            p_reg  <= {in_req.cam_pos_z, in_req.cam_pos_y, in_req.cam_pos_x};
        end
    end

    assign xx_e = RW'(xx_reg);
    assign yy_e = RW'(yy_reg);
    assign zz_e = RW'(zz_reg);
    assign xy_e = RW'(xy_reg);
    assign xz_e = RW'(xz_reg);
    assign yz_e = RW'(yz_reg);
    assign wx_e = RW'(wx_reg);
    assign wy_e = RW'(wy_reg);
    assign wz_e = RW'(wz_reg);

    // stage 2: rotation matrix, row-major, 2^-28 units
    always_comb
    begin
        rot_next.tw   = tw_reg;
        rot_next.p    = p_reg;
        rot_next.r[0] = ONE_Q28 - ((yy_e + zz_e) <<< 1);
        rot_next.r[1] = (xy_e - wz_e) <<< 1;
        rot_next.r[2] = (wy_e + xz_e) <<< 1;
        rot_next.r[3] = (xy_e + wz_e) <<< 1;
        rot_next.r[4] = ONE_Q28 - ((xx_e + zz_e) <<< 1);
        rot_next.r[5] = (yz_e - wx_e) <<< 1;
        rot_next.r[6] = (xz_e - wy_e) <<< 1;
        rot_next.r[7] = (yz_e + wx_e) <<< 1;
        rot_next.r[8] = ONE_Q28 - ((xx_e + yy_e) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
            rot_reg <= rot_next;
    end

    assign out_valid = v2_reg;
    assign out_rot   = rot_reg;

endmodule

// ===== rtl/core/ktbv_xform.sv =====
// Stages 3-4: rotate the twist and the tool offset into the base frame.
// Depends on ktbv_pkg.
module ktbv_xform (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ktbv_pkg::ktbv_rot_t   in_rot,
    input  logic [2:0][15:0]      tool_off,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ktbv_pkg::ktbv_xf_t    out_xf
);
    import ktbv_pkg::*;

    logic v1_reg, v2_reg;
    logic ld1, ld2;

    logic signed [RW-1:0]  col [3];
    logic signed [TPW-1:0] tp_next [3];
    logic signed [TPW-1:0] tp_reg  [3];
    logic signed [OPW-1:0] op_next [3][3];
    logic signed [OPW-1:0] op_reg  [3][3];
    logic                  is_lin_reg, is_ang_reg, quit_reg;
    logic [2:0][PW-1:0]    p_reg;
    ktbv_xf_t              xf_reg, xf_next;

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // stage 3: column pick and products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (in_rot.tw.axis)
                AX_X:    col[i] = $signed(in_rot.r[3*i]);
                AX_Y:    col[i] = $signed(in_rot.r[3*i+1]);
                AX_Z:    col[i] = $signed(in_rot.r[3*i+2]);
                default: col[i] = '0;
            endcase
            tp_next[i] = col[i] * in_rot.tw.mag;
            for (int j = 0; j < 3; j++)
                op_next[i][j] = $signed(in_rot.r[3*i+j]) * $signed(tool_off[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= in_valid;
            if (ld2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            tp_reg     <= tp_next;
            op_reg     <= op_next;
            is_lin_reg <= in_rot.tw.is_lin;
            is_ang_reg <= in_rot.tw.is_ang;
            quit_reg   <= in_rot.tw.quit;
            p_reg      <= in_rot.p;
        end
    end

    // stage 4: sum and round
    always_comb
    begin
        logic signed [RRW-1:0] t;
        xf_next.quit = quit_reg;
        xf_next.p    = p_reg;
        for (int i = 0; i < 3; i++)
        begin
            t             = rnd28(RDW'(tp_reg[i]));
            xf_next.rl[i] = is_lin_reg ? t : '0;
            xf_next.ra[i] = is_ang_reg ? t : '0;
            xf_next.ro[i] = rnd28(RDW'(op_reg[i][0]) + RDW'(op_reg[i][1])
                                  + RDW'(op_reg[i][2]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
            xf_reg <= xf_next;
    end

    assign out_valid = v2_reg;
    assign out_xf    = xf_reg;

endmodule

// ===== rtl/core/ktbv_adj.sv =====
// Stages 5-6: adjoint cross products, effector correction, saturation.
// Depends on ktbv_pkg.
module ktbv_adj (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ktbv_pkg::ktbv_xf_t    in_xf,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ktbv_pkg::ktbv_rsp_t   out_rsp
);
    import ktbv_pkg::*;

    localparam int NX1 [3] = '{1, 2, 0};
    localparam int NX2 [3] = '{2, 0, 1};

    logic v1_reg, v2_reg;
    logic ld1, ld2;

    logic signed [C1W-1:0] m1a_reg [3];
    logic signed [C1W-1:0] m1b_reg [3];
    logic signed [C2W-1:0] m2a_reg [3];
    logic signed [C2W-1:0] m2b_reg [3];
    logic signed [C1W-1:0] m1a_next [3];
    logic signed [C1W-1:0] m1b_next [3];
    logic signed [C2W-1:0] m2a_next [3];
    logic signed [C2W-1:0] m2b_next [3];
    logic [2:0][RRW-1:0]   rl_reg, ra_reg;
    logic                  quit_reg;
    logic signed [VW-1:0]  lin [3];
    logic signed [VW-1:0]  ang [3];
    ktbv_rsp_t             rsp_reg, rsp_next;

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    // stage 5: cross product terms, p x ra and ra x ro
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m1a_next[i] = $signed(in_xf.p[NX1[i]]) * $signed(in_xf.ra[NX2[i]]);
            m1b_next[i] = $signed(in_xf.p[NX2[i]]) * $signed(in_xf.ra[NX1[i]]);
            m2a_next[i] = $signed(in_xf.ra[NX1[i]]) * $signed(in_xf.ro[NX2[i]]);
            m2b_next[i] = $signed(in_xf.ra[NX2[i]]) * $signed(in_xf.ro[NX1[i]]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= in_valid;
            if (ld2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            m1a_reg  <= m1a_next;
            m1b_reg  <= m1b_next;
            m2a_reg  <= m2a_next;
            m2b_reg  <= m2b_next;
            rl_reg   <= in_xf.rl;
            ra_reg   <= in_xf.ra;
            quit_reg <= in_xf.quit;
        end
    end

    // stage 6: round, sum, saturate
    always_comb
    begin
        logic signed [CRW-1:0] c1r, c2r;
        for (int i = 0; i < 3; i++)
        begin
            c1r    = rnd12(CPW'(m1a_reg[i]) - CPW'(m1b_reg[i]));
            c2r    = rnd12(CPW'(m2a_reg[i]) - CPW'(m2b_reg[i]));
            lin[i] = sat_vel(SW'($signed(rl_reg[i])) + SW'(c1r) + SW'(c2r));
            ang[i] = sat_vel(SW'($signed(ra_reg[i])));
        end
        rsp_next.lin_vel_x = lin[0];
        rsp_next.lin_vel_y = lin[1];
        rsp_next.lin_vel_z = lin[2];
        rsp_next.ang_vel_x = ang[0];
        rsp_next.ang_vel_y = ang[1];
        rsp_next.ang_vel_z = ang[2];
        rsp_next.quit_flag = quit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
            rsp_reg <= rsp_next;
    end

    assign out_valid = v2_reg;
    assign out_rsp   = rsp_reg;

endmodule

// ===== rtl/core/key_twist_to_base_velocity_top.sv =====
// Pipeline: six register stages from request accept to result valid.
// Throughput: one request per cycle; a stage holds only while the stage after it
// is full and held, so bubbles close up and input is taken while a result waits.
// Reset: clears all stage valid bits; jog speed resets to 2294, tool offsets to 0.
// Top level of the key-twist to base-velocity block: config registers, three
// pipeline sections. Depends on ktbv_pkg, ktbv_rot, ktbv_xform, ktbv_adj.
module key_twist_to_base_velocity_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ktbv_pkg::ktbv_req_t   in_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ktbv_pkg::ktbv_rsp_t   out_rsp,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_wdata
);
    import ktbv_pkg::*;

    logic [15:0]      jog_speed_reg;
    logic [2:0][15:0] tool_off_reg;

    logic      rot_valid, rot_ready;
    ktbv_rot_t rot_data;
    logic      xf_valid, xf_ready;
    ktbv_xf_t  xf_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jog_speed_reg <= JOG_SPEED_RST;
            tool_off_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_JOG_SPEED: jog_speed_reg   <= cfg_wdata;
                REG_OFF_X:     tool_off_reg[0] <= cfg_wdata;
                REG_OFF_Y:     tool_off_reg[1] <= cfg_wdata;
                REG_OFF_Z:     tool_off_reg[2] <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    ktbv_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .jog_speed (jog_speed_reg),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_rot   (rot_data)
    );

    ktbv_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_rot    (rot_data),
        .tool_off  (tool_off_reg),
        .out_valid (xf_valid),
        .out_ready (xf_ready),
        .out_xf    (xf_data)
    );

    ktbv_adj u_adj (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xf_valid),
        .in_ready  (xf_ready),
        .in_xf     (xf_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp)
    );

    // quit key carries a zero twist all the way through
    a_quit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rsp.quit_flag |->
            out_rsp.lin_vel_x == '0 && out_rsp.lin_vel_y == '0 && out_rsp.lin_vel_z == '0 &&
            out_rsp.ang_vel_x == '0 && out_rsp.ang_vel_y == '0 && out_rsp.ang_vel_z == '0)
        else $error("quit result with nonzero velocity");

    // back-pressure reaches the input only from a held result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a held result");

    // an idle output never blocks the input or either inner section
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready && rot_ready && xf_ready)
        else $error("stage blocked while output is empty");

    a_speed_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_JOG_SPEED |=> jog_speed_reg == $past(cfg_wdata))
        else $error("jog speed write lost");

endmodule
